>>> src/kflt_pkg.sv
// shared types and constants for the keyframe interpolation table
// used by the controller, the datapath and the top level
`default_nettype none
package kflt_pkg;

  localparam int NUM_TRACKS = 3;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = $clog2(FRAC_W);
  localparam int MIN_PAIR   = 2;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LOCKED = 2'd1;
  localparam logic [1:0] ST_NEG    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // register word index
  localparam logic REG_LOCK = 1'b0;

  // one stored key: time and vector
  typedef struct packed {
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic [1:0] rd_trk;
    logic       wr_en;
    logic       wr_new;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       end_req;
    logic       end_rd;
    logic       save_prev;
    logic       div_start;
    logic       div_step;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       set_upd;
    logic       set_st;
    logic [1:0] st;
    logic       out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic [1:0] ch;
    logic       t_neg;
    logic       locked;
    logic       rd_lt;
    logic       rd_eq;
    logic       in_range;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> src/kflt_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module kflt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/kflt_ctrl.sv
// sequencer for insert, delete and evaluate requests
// depends on kflt_pkg; drives the datapath through ctl_t commands
`default_nettype none
module kflt_ctrl #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire kflt_pkg::sts_t                   sts,
  input  wire logic [$clog2(MAX_KEYS+1)-1:0]    cnt [kflt_pkg::NUM_TRACKS],
  output kflt_pkg::ctl_t                        cmd,
  output logic      [$clog2(MAX_KEYS+1)-1:0]    rd_idx,
  output logic      [$clog2(MAX_KEYS+1)-1:0]    wr_idx
);
  import kflt_pkg::*;

  localparam int IW = $clog2(MAX_KEYS+1);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_INS_SCAN, S_INS_DEC, S_SH_CHK, S_SH_W,
    S_DEL_SCAN, S_DEL_CHK, S_DEL_W, S_RAISE, S_RAISE_CMP,
    S_EV_FIRST, S_EV_SCAN, S_DIV, S_MUL_X, S_MUL_Y, S_MUL_Z, S_ACC_Z, S_FIN
  } state_t;

  state_t            state, state_next;
  logic [IW-1:0]     idx, idx_next;
  logic [IW-1:0]     j, j_next;
  logic              found, found_next;
  logic [1:0]        trk, trk_next;
  logic [STEP_W-1:0] step, step_next;
  logic [IW-1:0]     cnt_ch, cnt_trk;
  logic              ch_ok;

  always_comb begin
    cnt_ch  = '0;
    cnt_trk = '0;
    for (int k = 0; k < NUM_TRACKS; k++) begin
      if (sts.ch == 2'(k)) begin
        cnt_ch = cnt[k];
      end
      if (trk == 2'(k)) begin
        cnt_trk = cnt[k];
      end
    end
  end

  assign ch_ok    = (sts.ch < 2'(NUM_TRACKS));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    j_next     = j;
    found_next = found;
    trk_next   = trk;
    step_next  = step;
    cmd        = '0;
    cmd.rd_trk = sts.ch;
    rd_idx     = '0;
    wr_idx     = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_next = '0;
        case (sts.req)
          REQ_INSERT: begin
            if (sts.t_neg) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_NEG;
              state_next = S_FIN;
            end else if (sts.locked) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_LOCKED;
              state_next = S_FIN;
            end else if (!ch_ok) begin
              state_next = S_FIN;
            end else if (cnt_ch == '0) begin
              found_next = 1'b0;
              state_next = S_INS_DEC;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_INS_SCAN;
            end
          end
          REQ_DELETE: begin
            if (sts.locked) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_LOCKED;
              state_next = S_FIN;
            end else if (!ch_ok) begin
              state_next = S_FIN;
            end else if (cnt_ch == '0) begin
              trk_next   = '0;
              state_next = S_RAISE;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_DEL_SCAN;
            end
          end
          REQ_EVAL: begin
            if (!ch_ok || cnt_ch < IW'(MIN_PAIR)) begin
              state_next = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_EV_FIRST;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_INS_SCAN: begin
        if (sts.rd_lt) begin
          idx_next = idx + 1'b1;
          if (idx + 1'b1 < cnt_ch) begin
            cmd.rd_en = 1'b1;
            rd_idx    = idx + 1'b1;
          end else begin
            found_next = 1'b0;
            state_next = S_INS_DEC;
          end
        end else begin
          found_next = sts.rd_eq;
          state_next = S_INS_DEC;
        end
      end
      S_INS_DEC: begin
        if (found) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.end_req = 1'b1;
          state_next  = S_FIN;
        end else if (cnt_ch == IW'(MAX_KEYS)) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_FULL;
          state_next = S_FIN;
        end else begin
          j_next     = cnt_ch;
          state_next = S_SH_CHK;
        end
      end
      // open a gap at the insert point, top entry first
      S_SH_CHK: begin
        if (j > idx) begin
          cmd.rd_en  = 1'b1;
          rd_idx     = j - 1'b1;
          state_next = S_SH_W;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.end_req = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_SH_W: begin
        cmd.wr_en  = 1'b1;
        wr_idx     = j;
        j_next     = j - 1'b1;
        state_next = S_SH_CHK;
      end
      S_DEL_SCAN: begin
        if (sts.rd_eq) begin
          j_next     = idx;
          state_next = S_DEL_CHK;
        end else if (idx + 1'b1 < cnt_ch) begin
          idx_next  = idx + 1'b1;
          cmd.rd_en = 1'b1;
          rd_idx    = idx + 1'b1;
        end else begin
          trk_next   = '0;
          state_next = S_RAISE;
        end
      end
      // close the gap, lowest entry first
      S_DEL_CHK: begin
        if (j + 1'b1 < cnt_ch) begin
          cmd.rd_en  = 1'b1;
          rd_idx     = j + 1'b1;
          state_next = S_DEL_W;
        end else begin
          cmd.cnt_dec = 1'b1;
          trk_next    = '0;
          state_next  = S_RAISE;
        end
      end
      S_DEL_W: begin
        cmd.wr_en  = 1'b1;
        wr_idx     = j;
        j_next     = j + 1'b1;
        state_next = S_DEL_CHK;
      end
      // end time rises to the last key of every track with a pair, never falls
      S_RAISE: begin
        if (cnt_trk >= IW'(MIN_PAIR)) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_trk = trk;
          rd_idx     = cnt_trk - 1'b1;
          state_next = S_RAISE_CMP;
        end else if (trk == 2'(NUM_TRACKS - 1)) begin
          state_next = S_FIN;
        end else begin
          trk_next = trk + 1'b1;
        end
      end
      S_RAISE_CMP: begin
        cmd.end_rd = 1'b1;
        if (trk == 2'(NUM_TRACKS - 1)) begin
          state_next = S_FIN;
        end else begin
          trk_next   = trk + 1'b1;
          state_next = S_RAISE;
        end
      end
      S_EV_FIRST: begin
        cmd.save_prev = 1'b1;
        cmd.rd_en     = 1'b1;
        rd_idx        = IW'(1);
        idx_next      = IW'(1);
        state_next    = S_EV_SCAN;
      end
      S_EV_SCAN: begin
        if (sts.in_range) begin
          cmd.div_start = 1'b1;
          step_next     = '0;
          state_next    = S_DIV;
        end else if (idx + 1'b1 < cnt_ch) begin
          cmd.save_prev = 1'b1;
          cmd.rd_en     = 1'b1;
          rd_idx        = idx + 1'b1;
          idx_next      = idx + 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(FRAC_W - 1)) begin
          state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd0;
        state_next  = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd1;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = 2'd0;
        state_next  = S_MUL_Z;
      end
      S_MUL_Z: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd2;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = 2'd1;
        state_next  = S_ACC_Z;
      end
      S_ACC_Z: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = 2'd2;
        cmd.set_upd = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      j     <= '0;
      found <= 1'b0;
      trk   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      j     <= j_next;
      found <= found_next;
      trk   <= trk_next;
      step  <= step_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an unread item");
  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (wr_idx < IW'(MAX_KEYS)))
    else $error("key write beyond track");
`endif

endmodule
`default_nettype wire

>>> src/kflt_dp.sv
// datapath: key store, counts, end time, divider, interpolator, output register
// depends on kflt_pkg and kflt_ram
`default_nettype none
module kflt_dp #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 locked,
  input  wire kflt_pkg::ctl_t                       cmd,
  input  wire logic [$clog2(MAX_KEYS+1)-1:0]        rd_idx,
  input  wire logic [$clog2(MAX_KEYS+1)-1:0]        wr_idx,
  output kflt_pkg::sts_t                            sts,
  output logic      [$clog2(MAX_KEYS+1)-1:0]        cnt [kflt_pkg::NUM_TRACKS],
  input  wire logic [1:0]                           req_type,
  input  wire logic [1:0]                           channel,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   key_time,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   value_x,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   value_y,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   value_z,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [1:0]                           status,
  output logic                                      updated,
  output logic signed [kflt_pkg::DATA_W-1:0]        out_x,
  output logic signed [kflt_pkg::DATA_W-1:0]        out_y,
  output logic signed [kflt_pkg::DATA_W-1:0]        out_z,
  output logic signed [kflt_pkg::DATA_W-1:0]        end_time_out
);
  import kflt_pkg::*;

  localparam int IW    = $clog2(MAX_KEYS+1);
  localparam int DEPTH = NUM_TRACKS * MAX_KEYS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = DATA_W + 1;
  localparam int PW    = SW + FRAC_W + 1;

  logic [1:0]               req_q, ch_q;
  entry_t                   item_q, rd_data, prev, nxt, wr_data;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic signed [DATA_W-1:0] end_time;
  logic [SW-1:0]            span, rem;
  logic [SW:0]              rem2;
  logic [FRAC_W-1:0]        quo;
  logic signed [SW-1:0]     diff;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PW-1:0]     prod;
  logic signed [DATA_W-1:0] mul_a, mul_b, acc_a, acc_sum;
  logic [1:0]               res_st;
  logic                     res_upd;
  logic signed [DATA_W-1:0] res_x, res_y, res_z;

  assign rd_addr = AW'(cmd.rd_trk) * AW'(MAX_KEYS) + AW'(rd_idx);
  assign wr_addr = AW'(ch_q) * AW'(MAX_KEYS) + AW'(wr_idx);
  assign wr_data = cmd.wr_new ? item_q : rd_data;

  kflt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign sts.req      = req_q;
  assign sts.ch       = ch_q;
  assign sts.t_neg    = item_q.t[DATA_W-1];
  assign sts.locked   = locked;
  assign sts.rd_lt    = (rd_data.t < item_q.t);
  assign sts.rd_eq    = (rd_data.t == item_q.t);
  assign sts.in_range = (item_q.t >= prev.t) && (item_q.t < rd_data.t);
  assign sts.out_free = !out_valid || !out_stall;

  // one quotient bit a cycle, remainder stays below span
  assign rem2 = {rem, 1'b0};

  always_comb begin
    case (cmd.mul_sel)
      2'd0:    begin mul_a = prev.x; mul_b = nxt.x; end
      2'd1:    begin mul_a = prev.y; mul_b = nxt.y; end
      default: begin mul_a = prev.z; mul_b = nxt.z; end
    endcase
    case (cmd.acc_sel)
      2'd0:    acc_a = prev.x;
      2'd1:    acc_a = prev.y;
      default: acc_a = prev.z;
    endcase
  end

  assign diff    = SW'(mul_b) - SW'(mul_a);
  assign frac_s  = $signed({1'b0, quo});
  // floor of the scaled product is an arithmetic shift
  assign acc_sum = acc_a + prod[FRAC_W +: DATA_W];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q    <= req_type;
      ch_q     <= channel;
      item_q.t <= key_time;
      item_q.x <= value_x;
      item_q.y <= value_y;
      item_q.z <= value_z;
      res_st   <= ST_OK;
      res_upd  <= 1'b0;
      res_x    <= '0;
      res_y    <= '0;
      res_z    <= '0;
    end
    if (cmd.set_st) begin
      res_st <= cmd.st;
    end
    if (cmd.set_upd) begin
      res_upd <= 1'b1;
    end
    if (cmd.save_prev) begin
      prev <= rd_data;
    end
    if (cmd.div_start) begin
      nxt  <= rd_data;
      span <= SW'(rd_data.t) - SW'(prev.t);
      rem  <= SW'(item_q.t) - SW'(prev.t);
      quo  <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, span}) begin
        rem <= SW'(rem2 - {1'b0, span});
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        rem <= rem2[SW-1:0];
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.mul_en) begin
      prod <= PW'(diff) * PW'(frac_s);
    end
    if (cmd.acc_en) begin
      case (cmd.acc_sel)
        2'd0:    res_x <= acc_sum;
        2'd1:    res_y <= acc_sum;
        default: res_z <= acc_sum;
      endcase
    end
    if (cmd.out_load) begin
      status       <= res_st;
      updated      <= res_upd;
      out_x        <= res_x;
      out_y        <= res_y;
      out_z        <= res_z;
      end_time_out <= end_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      end_time  <= '0;
      for (int k = 0; k < NUM_TRACKS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.end_req && (end_time < item_q.t)) begin
        end_time <= item_q.t;
      end else if (cmd.end_rd && (end_time < rd_data.t)) begin
        end_time <= rd_data.t;
      end
      for (int k = 0; k < NUM_TRACKS; k++) begin
        if (ch_q == 2'(k)) begin
          if (cmd.cnt_inc) begin
            cnt[k] <= cnt[k] + 1'b1;
          end else if (cmd.cnt_dec) begin
            cnt[k] <= cnt[k] - 1'b1;
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= IW'(MAX_KEYS)) && (cnt[1] <= IW'(MAX_KEYS)) && (cnt[2] <= IW'(MAX_KEYS)))
    else $error("track count above capacity");
  a_end_rises: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($signed(end_time) >= $signed($past(end_time))))
    else $error("end time fell");
  a_inc_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !cmd.cnt_dec)
    else $error("count raised and lowered together");
`endif

endmodule
`default_nettype wire

>>> src/keyframe_lerp_table_unit.sv
// keyframe interpolation table: three sorted key tracks with linear evaluation
// Input items (insert, delete, evaluate) enter on in_valid/in_stall; each gives one
// result item on out_valid/out_stall. The lock register sits at byte address 0.
// in_stall is low only while the sequencer is idle, so one item is worked at a time;
// a finished result waits in the output register while the next item is taken.
// An insert scans the track for the key position; a new key then shifts the later
// keys up, top entry first, and is written into the gap, while a replace is written
// in place. A delete scans for the key, shifts the later keys down, then rechecks
// the end time against the last key of every track with a pair, also for a missing key.
// An evaluate scans for the bracketing keys, runs the bit-per-cycle fraction divider
// and then multiplies and accumulates x, y and z in turn. Refused and no-op items
// go straight to the result. The key memory moves one entry at a time.
// Reset clears the counts, the end time, the lock and the output valid; key
// memory holds no reset value and is only read below a track's count.
// A stalled result holds its fields; a second result waits in the sequencer
// until the output register is free.
`default_nettype none
module keyframe_lerp_table_unit #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic      [31:0]                          prdata,
  output logic                                      pready,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           req_type,
  input  wire logic [1:0]                           channel,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   key_time,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   value_x,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   value_y,
  input  wire logic signed [kflt_pkg::DATA_W-1:0]   value_z,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [1:0]                           status,
  output logic                                      updated,
  output logic signed [kflt_pkg::DATA_W-1:0]        out_x,
  output logic signed [kflt_pkg::DATA_W-1:0]        out_y,
  output logic signed [kflt_pkg::DATA_W-1:0]        out_z,
  output logic signed [kflt_pkg::DATA_W-1:0]        end_time_out
);
  import kflt_pkg::*;

  localparam int IW = $clog2(MAX_KEYS+1);

  logic          editing_locked;
  ctl_t          cmd;
  sts_t          sts;
  logic [IW-1:0] cnt [NUM_TRACKS];
  logic [IW-1:0] rd_idx, wr_idx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOCK) ? {31'd0, editing_locked} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      editing_locked <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LOCK)) begin
      editing_locked <= pwdata[0];
    end
  end

  kflt_ctrl #(
    .MAX_KEYS (MAX_KEYS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cnt      (cnt),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .wr_idx   (wr_idx)
  );

  kflt_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .locked       (editing_locked),
    .cmd          (cmd),
    .rd_idx       (rd_idx),
    .wr_idx       (wr_idx),
    .sts          (sts),
    .cnt          (cnt),
    .req_type     (req_type),
    .channel      (channel),
    .key_time     (key_time),
    .value_x      (value_x),
    .value_y      (value_y),
    .value_z      (value_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .updated      (updated),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .end_time_out (end_time_out)
  );

endmodule
`default_nettype wire

>>> tb/kflt_checker.sv
// keyframe table checker: watches the register port and both item channels,
// keeps its own copy of the three key tracks and compares every result item
// depends on kflt_pkg for request and status codes
`default_nettype none
module kflt_checker #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  input  wire logic                               pready,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire logic [1:0]                         req_type,
  input  wire logic [1:0]                         channel,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] key_time,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] value_x,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] value_y,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] value_z,
  input  wire logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire logic [1:0]                         status,
  input  wire logic                               updated,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] out_x,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] out_y,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] out_z,
  input  wire logic signed [kflt_pkg::DATA_W-1:0] end_time_out,
  output int                                      pending,
  output int                                      errors
);
  import kflt_pkg::*;

  typedef struct {
    logic [1:0]               st;
    logic                     upd;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] endt;
  } lerp_result_t;

  lerp_result_t             result_q[$];
  logic signed [DATA_W-1:0] trk_t[NUM_TRACKS][MAX_KEYS];
  logic signed [DATA_W-1:0] trk_x[NUM_TRACKS][MAX_KEYS];
  logic signed [DATA_W-1:0] trk_y[NUM_TRACKS][MAX_KEYS];
  logic signed [DATA_W-1:0] trk_z[NUM_TRACKS][MAX_KEYS];
  int                       trk_cnt[NUM_TRACKS];
  logic signed [DATA_W-1:0] anim_end;
  logic                     locked;

  // a + floor((b - a) * frac / 65536)
  function automatic logic signed [DATA_W-1:0] blend(logic signed [DATA_W-1:0] a,
                                                     logic signed [DATA_W-1:0] b,
                                                     longint frac);
    longint d;
    d = (longint'(b) - longint'(a)) * frac;
    return DATA_W'(longint'(a) + (d >>> FRAC_W));
  endfunction

  task automatic apply_key_op(input logic [1:0] req, input logic [1:0] ch,
                              input logic signed [DATA_W-1:0] t,
                              input logic signed [DATA_W-1:0] vx,
                              input logic signed [DATA_W-1:0] vy,
                              input logic signed [DATA_W-1:0] vz);
    lerp_result_t r;
    int           n;
    int           p;
    int           i;
    bit           found;
    longint       span;
    longint       off;
    longint       frac;
    r.st = ST_OK;
    r.upd = 1'b0;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    if (req == REQ_INSERT) begin
      if (t < 0) begin
        r.st = ST_NEG;
      end else if (locked) begin
        r.st = ST_LOCKED;
      end else if (ch < NUM_TRACKS) begin
        n = trk_cnt[ch];
        p = 0;
        while (p < n && trk_t[ch][p] < t) p++;
        found = (p < n) && (trk_t[ch][p] == t);
        if (!found && n >= MAX_KEYS) begin
          r.st = ST_FULL;
        end else begin
          if (!found) begin
            for (i = n; i > p; i--) begin
              trk_t[ch][i] = trk_t[ch][i-1];
              trk_x[ch][i] = trk_x[ch][i-1];
              trk_y[ch][i] = trk_y[ch][i-1];
              trk_z[ch][i] = trk_z[ch][i-1];
            end
            trk_t[ch][p] = t;
            trk_cnt[ch] = n + 1;
          end
          trk_x[ch][p] = vx;
          trk_y[ch][p] = vy;
          trk_z[ch][p] = vz;
          if (anim_end < t) anim_end = t;
        end
      end
    end else if (req == REQ_DELETE) begin
      if (locked) begin
        r.st = ST_LOCKED;
      end else if (ch < NUM_TRACKS) begin
        n = trk_cnt[ch];
        p = 0;
        while (p < n && trk_t[ch][p] != t) p++;
        if (p < n) begin
          for (i = p; i + 1 < n; i++) begin
            trk_t[ch][i] = trk_t[ch][i+1];
            trk_x[ch][i] = trk_x[ch][i+1];
            trk_y[ch][i] = trk_y[ch][i+1];
            trk_z[ch][i] = trk_z[ch][i+1];
          end
          trk_cnt[ch] = n - 1;
        end
        // end time only ever rises, to the last key of any usable track
        for (i = 0; i < NUM_TRACKS; i++)
          if (trk_cnt[i] >= MIN_PAIR && anim_end < trk_t[i][trk_cnt[i]-1])
            anim_end = trk_t[i][trk_cnt[i]-1];
      end
    end else if (req == REQ_EVAL) begin
      if (ch < NUM_TRACKS && trk_cnt[ch] >= MIN_PAIR) begin
        for (i = 0; i + 1 < trk_cnt[ch]; i++) begin
          if (!r.upd && t >= trk_t[ch][i] && t < trk_t[ch][i+1]) begin
            span = longint'(trk_t[ch][i+1]) - longint'(trk_t[ch][i]);
            off  = longint'(t) - longint'(trk_t[ch][i]);
            frac = (off * 65536) / span;
            r.x = blend(trk_x[ch][i], trk_x[ch][i+1], frac);
            r.y = blend(trk_y[ch][i], trk_y[ch][i+1], frac);
            r.z = blend(trk_z[ch][i], trk_z[ch][i+1], frac);
            r.upd = 1'b1;
          end
        end
      end
    end
    r.endt = anim_end;
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    lerp_result_t e;
    if (rst) begin
      result_q.delete();
      trk_cnt = '{default: 0};
      anim_end = '0;
      locked = 1'b0;
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_LOCK)
        locked = pwdata[0];
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result item: status %0d updated %0d", $time,
                   status, updated);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (status !== e.st || updated !== e.upd || out_x !== e.x ||
              out_y !== e.y || out_z !== e.z || end_time_out !== e.endt) begin
            $display("%0t mismatch expected st %0d upd %0d xyz %h %h %h end %h", $time,
                     e.st, e.upd, e.x, e.y, e.z, e.endt);
            $display("%0t          actual   st %0d upd %0d xyz %h %h %h end %h", $time,
                     status, updated, out_x, out_y, out_z, end_time_out);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        apply_key_op(req_type, channel, key_time, value_x, value_y, value_z);
    end
    pending = result_q.size();
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// keyframe table testbench top: clock, reset, stimulus and verdict
// depends on kflt_pkg, keyframe_lerp_table_unit and kflt_checker
`default_nettype none
module tb_top;
  import kflt_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = '0;
  logic [1:0]        channel = '0;
  logic signed [31:0] key_time = '0;
  logic signed [31:0] value_x = '0;
  logic signed [31:0] value_y = '0;
  logic signed [31:0] value_z = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic              updated;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] end_time_out;
  int                pending;
  int                errors;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_kick = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  keyframe_lerp_table_unit u_top (.*);

  kflt_checker u_chk (.*);

  always #10 clk = ~clk;

  // receiver: random stalls, plus a long hold-off whenever hold_kick toggles
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_lock(input logic val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_LOCK, 2'b00};
    pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] req, input logic [1:0] ch,
                           input logic [31:0] t, input logic [31:0] vx,
                           input logic [31:0] vy, input logic [31:0] vz);
    in_valid <= 1'b1;
    req_type <= req;
    channel <= ch;
    key_time <= t;
    value_x <= vx;
    value_y <= vy;
    value_z <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // sender pauses until every result has come back, then lets the block settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] key_slot();
    return {20'($urandom_range(0, 40)), 12'd0};
  endfunction

  task automatic random_item;
    logic [1:0]  req;
    logic [1:0]  ch;
    logic [31:0] t;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 40) req = REQ_INSERT;
    else if (pick < 60) req = REQ_DELETE;
    else if (pick < 95) req = REQ_EVAL;
    else req = 2'd3;
    ch = ($urandom_range(99) < 5) ? 2'd3 : 2'($urandom_range(0, NUM_TRACKS - 1));
    pick = $urandom_range(99);
    if (pick < 8) t = $urandom;
    else if (pick < 14) t = {1'b1, 31'($urandom)};
    else if (req == REQ_EVAL) t = $urandom_range(0, 32'h2A000);
    else t = key_slot();
    send_item(req, ch, t, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int ph;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of time and value, replace, out-of-range evaluates, unused codes
    send_item(REQ_INSERT, 2'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_item(REQ_INSERT, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(REQ_EVAL, 2'd0, 32'h4000_0000, 0, 0, 0);
    send_item(REQ_EVAL, 2'd0, 32'h7FFF_FFFF, 0, 0, 0);
    send_item(REQ_EVAL, 2'd0, 32'hFFFF_FFFF, 0, 0, 0);
    send_item(REQ_INSERT, 2'd0, 32'd0, 32'd1, 32'd2, 32'd3);
    send_item(REQ_EVAL, 2'd0, 32'd1, 0, 0, 0);
    send_item(REQ_INSERT, 2'd1, 32'hFFFF_FFFF, 1, 1, 1);
    send_item(REQ_INSERT, 2'd1, 32'h8000_0000, 1, 1, 1);
    send_item(REQ_EVAL, 2'd1, 32'd0, 0, 0, 0);
    send_item(REQ_INSERT, 2'd3, 32'd5, 7, 7, 7);
    send_item(REQ_DELETE, 2'd3, 32'd5, 0, 0, 0);
    send_item(REQ_EVAL, 2'd3, 32'd5, 0, 0, 0);
    send_item(2'd3, 2'd0, 32'd0, 0, 0, 0);
    send_item(REQ_DELETE, 2'd0, 32'd12345, 0, 0, 0);
    send_item(REQ_DELETE, 2'd0, 32'h7FFF_FFFF, 0, 0, 0);
    send_item(REQ_EVAL, 2'd0, 32'd0, 0, 0, 0);
    send_item(REQ_INSERT, 2'd2, 32'h1_0000, 32'hFFFF_0000, 32'd100, 32'h8000_0000);
    send_item(REQ_INSERT, 2'd2, 32'h2_0000, 32'h0001_0000, 32'hFFFF_FF9C, 32'h7FFF_FFFF);
    send_item(REQ_EVAL, 2'd2, 32'h1_8000, 0, 0, 0);
    drain();
    write_lock(1'b1);
    send_item(REQ_INSERT, 2'd0, 32'hFFFF_FFFB, 0, 0, 0);
    send_item(REQ_INSERT, 2'd0, 32'd1, 0, 0, 0);
    send_item(REQ_DELETE, 2'd2, 32'h1_0000, 0, 0, 0);
    send_item(REQ_EVAL, 2'd2, 32'h1_4000, 0, 0, 0);
    drain();
    write_lock(1'b0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 85;
          stall_pct = 0;
          write_lock(1'b1);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 85;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      for (k = 0; k < 405; k++) begin
        if (ph == 3 && k == 50) hold_kick = ~hold_kick;
        random_item();
      end
      drain();
      if (ph == 1) write_lock(1'b0);
    end

    stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
src/kflt_pkg.sv
src/kflt_ram.sv
src/kflt_ctrl.sv
src/kflt_dp.sv
src/keyframe_lerp_table_unit.sv
tb/kflt_checker.sv
tb/tb_top.sv
